/* src/tfrc_pkg.sv */
package tfrc_pkg;

    // Instruction opcode field, bits 7:6
    localparam logic [1:0] OPC_LOAD  = 2'b00;
    localparam logic [1:0] OPC_ADD   = 2'b01;
    localparam logic [1:0] OPC_SUB   = 2'b10;
    localparam logic [1:0] OPC_MISC  = 2'b11;

    // Extra field, bits 1:0, under the misc opcode
    localparam logic [1:0] EXT_DISPLAY = 2'b00;
    localparam logic [1:0] EXT_CMP1    = 2'b01;
    localparam logic [1:0] EXT_CMP2    = 2'b10;
    localparam logic [1:0] EXT_INVALID = 2'b11;

    // Queue between decode and execute
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [7:0] data_t;
    typedef logic [1:0] reg_idx_t;

    typedef enum logic [2:0] {
        KIND_LOAD,
        KIND_ADD,
        KIND_SUB,
        KIND_DISPLAY,
        KIND_COMPARE,
        KIND_INVALID
    } op_kind_t;

    // Decoded instruction handed from the front to the back
    typedef struct packed {
        op_kind_t   kind;
        reg_idx_t   rd;
        reg_idx_t   ra;      // first read port: rs
        reg_idx_t   rb;      // second read port: rt, or rd for display/compare
        data_t      imm;     // sign-extended immediate
        logic [1:0] skip;    // skip amount on an equal compare
    } dec_op_t;

    // One result beat
    typedef struct packed {
        logic       display_valid;
        data_t      display_value;
        logic [1:0] skip_count;
        logic       invalid;
    } result_t;

endpackage

/* src/tfrc_front.sv */
module tfrc_front
    import tfrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  logic    [7:0] instruction,
    output logic    full,
    output logic    issue_valid,
    output dec_op_t issue_op,
    input  logic    issue_full
);

    logic    valid_reg;
    logic    valid_next;
    dec_op_t op_reg;
    dec_op_t op_next;
    logic    take;
    logic    advance;

    // Classify the incoming instruction
    always_comb
    begin
        op_next.rd   = instruction[5:4];
        op_next.ra   = instruction[3:2];
        op_next.rb   = instruction[1:0];
        op_next.imm  = {{4{instruction[3]}}, instruction[3:0]};
        op_next.skip = instruction[1:0];
        op_next.kind = KIND_INVALID;
        unique case (instruction[7:6])
            OPC_LOAD: op_next.kind = KIND_LOAD;
            OPC_ADD:  op_next.kind = KIND_ADD;
            OPC_SUB:  op_next.kind = KIND_SUB;
            OPC_MISC:
            begin
                unique case (instruction[1:0])
                    EXT_DISPLAY:
                    begin
                        op_next.kind = KIND_DISPLAY;
                        op_next.rb   = instruction[5:4];
                    end
                    EXT_CMP1, EXT_CMP2:
                    begin
                        op_next.kind = KIND_COMPARE;
                        op_next.rb   = instruction[5:4];
                    end
                    EXT_INVALID: op_next.kind = KIND_INVALID;
                    default:     op_next.kind = KIND_INVALID;
                endcase
            end
            default: op_next.kind = KIND_INVALID;
        endcase
    end

    // Hold a decoded beat until the queue takes it
    assign advance     = valid_reg && !issue_full;
    assign full        = valid_reg && issue_full;
    assign take        = push && !full;
    assign issue_valid = valid_reg;
    assign issue_op    = op_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= op_next;
        end
    end

endmodule

/* src/tfrc_queue.sv */
module tfrc_queue
    import tfrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    input  dec_op_t wr_op,
    output logic    q_full,
    input  logic    rd_pop,
    output logic    q_empty,
    output dec_op_t rd_op
);

    dec_op_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_valid && !q_full;
    assign do_rd   = rd_pop && !q_empty;
    assign rd_op   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

/* src/tfrc_exec.sv */
module tfrc_exec
    import tfrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  dec_op_t q_op,
    output logic    q_pop,
    output logic    res_valid,
    output result_t res,
    input  logic    res_pop
);

    data_t   rf_reg [4];
    data_t   rf_next [4];
    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;
    result_t res_next;
    data_t   a_val;
    data_t   b_val;
    data_t   wr_val;
    logic    wr_en;
    logic    fire;

    // Execute when an op waits and the result slot is free or draining
    assign fire  = !q_empty && (!res_valid_reg || res_pop);
    assign q_pop = fire;
    assign a_val = rf_reg[q_op.ra];
    assign b_val = rf_reg[q_op.rb];

    always_comb
    begin
        wr_en    = 1'b0;
        wr_val   = q_op.imm;
        res_next = '0;
        case (q_op.kind)
            KIND_LOAD:
            begin
                wr_en  = 1'b1;
                wr_val = q_op.imm;
            end
            KIND_ADD:
            begin
                wr_en  = 1'b1;
                wr_val = a_val + b_val;
            end
            KIND_SUB:
            begin
                wr_en  = 1'b1;
                wr_val = a_val - b_val;
            end
            KIND_DISPLAY:
            begin
                res_next.display_valid = 1'b1;
                res_next.display_value = b_val;
            end
            KIND_COMPARE:
            begin
                res_next.skip_count = (a_val == b_val) ? q_op.skip : 2'b00;
            end
            default:
            begin
                res_next.invalid = 1'b1;
            end
        endcase
    end

    // Write back the destination register
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rf_next[i] = rf_reg[i];
        end
        if (fire && wr_en)
        begin
            rf_next[q_op.rd] = wr_val;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rf_reg[i] <= '0;
            end
            res_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                rf_reg[i] <= rf_next[i];
            end
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the result beat until popped
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* src/tiny_four_register_calculator_core.sv */
// Channel   Handshake           Beat contents
// input     push / full         instruction[7:0]
// result    empty / pop         display_valid, display_value[7:0], skip_count[1:0], invalid
//
// One instruction per cycle sustained while results are popped; a result passes through the
// decode register, then the op queue and execute into the result register.
// The register-file read, add/sub and write together in the execute stage set the rate.
// Reset clears the four registers to zero and empties every stage.
// A stalled result side fills the result register, the two-entry op queue, then the decode
// register, then raises full.
module tiny_four_register_calculator_core
    import tfrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  instruction,
    output logic        empty,
    input  logic        pop,
    output logic        display_valid,
    output logic signed [7:0] display_value,
    output logic [1:0]  skip_count,
    output logic        invalid
);

    logic    issue_valid;
    dec_op_t issue_op;
    logic    issue_full;
    logic    q_empty;
    logic    q_pop;
    dec_op_t q_op;
    logic    res_valid;
    result_t res;

    tfrc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .instruction (instruction),
        .full        (full),
        .issue_valid (issue_valid),
        .issue_op    (issue_op),
        .issue_full  (issue_full)
    );

    tfrc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (issue_valid),
        .wr_op    (issue_op),
        .q_full   (issue_full),
        .rd_pop   (q_pop),
        .q_empty  (q_empty),
        .rd_op    (q_op)
    );

    tfrc_exec u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    // Drive the result ports
    assign empty         = !res_valid;
    assign display_valid = res.display_valid;
    assign display_value = signed'(res.display_value);
    assign skip_count    = res.skip_count;
    assign invalid       = res.invalid;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import tfrc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 550;
    localparam int DRAIN_CYCLES  = 12;
    localparam int IDLE_PERCENT  = 12;
    localparam int CALM_START    = 300;
    localparam int CALM_END      = 450;
    localparam int HOLD_AT_BEAT  = 150;
    localparam int HOLD_CYCLES   = 80;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              push        = 1'b0;
    logic [7:0]        instruction = 8'h00;
    logic              pop         = 1'b0;
    logic              full;
    logic              empty;
    logic              display_valid;
    logic signed [7:0] display_value;
    logic [1:0]        skip_count;
    logic              invalid;

    // Instructions waiting to be offered, and results owed by the core
    logic [7:0] pending_instructions[$];
    result_t    expected_results[$];

    // Shadow copy of the four registers
    data_t reg_model[4];

    int cycle_count  = 0;
    int error_count  = 0;
    int beats_popped = 0;
    int hold_left    = 0;

    tiny_four_register_calculator_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .instruction   (instruction),
        .empty         (empty),
        .pop           (pop),
        .display_valid (display_valid),
        .display_value (display_value),
        .skip_count    (skip_count),
        .invalid       (invalid)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Execute one instruction on the shadow registers and give its result
    function automatic result_t exec_instruction(input logic [7:0] ins);
        result_t  res;
        reg_idx_t rd;
        reg_idx_t rs;
        reg_idx_t rt;
        data_t    a;
        data_t    b;
        rd  = ins[5:4];
        rs  = ins[3:2];
        rt  = ins[1:0];
        a   = reg_model[rs];
        b   = reg_model[rt];
        res = '0;
        case (ins[7:6])
            OPC_LOAD: reg_model[rd] = {{4{ins[3]}}, ins[3:0]};
            OPC_ADD:  reg_model[rd] = a + b;
            OPC_SUB:  reg_model[rd] = a - b;
            default:
            begin
                case (rt)
                    EXT_DISPLAY:
                    begin
                        res.display_valid = 1'b1;
                        res.display_value = reg_model[rd];
                    end
                    EXT_INVALID: res.invalid = 1'b1;
                    default:
                    begin
                        // compare: skip only when the registers match
                        if (reg_model[rd] == a)
                            res.skip_count = rt;
                    end
                endcase
            end
        endcase
        return res;
    endfunction

    function automatic logic [7:0] make_ins(input logic [1:0] op, input logic [1:0] rd,
                                            input logic [1:0] rs, input logic [1:0] rt);
        return {op, rd, rs, rt};
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endtask

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Driver: offer pending instructions, predict each beat as it is taken
    always @(posedge clk)
    begin : driver
        logic gap;
        gap = (cycle_count < CALM_START || cycle_count >= CALM_END)
              && ($urandom_range(0, 99) < IDLE_PERCENT);
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_results.push_back(exec_instruction(instruction));
                void'(pending_instructions.pop_front());
            end
            if (pending_instructions.size() > 0 && !gap)
            begin
                push        <= 1'b1;
                instruction <= pending_instructions[0];
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual %0d",
                             $time, $signed(display_value));
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (display_valid !== want.display_valid)
                        report_mismatch("display_valid", want.display_valid, display_valid);
                    if (display_value !== want.display_value)
                        report_mismatch("display_value", $signed(want.display_value),
                                        display_value);
                    if (skip_count !== want.skip_count)
                        report_mismatch("skip_count", want.skip_count, skip_count);
                    if (invalid !== want.invalid)
                        report_mismatch("invalid", want.invalid, invalid);
                end
                beats_popped++;
                // hold off once for a long stretch so the core fills and stalls
                if (beats_popped == HOLD_AT_BEAT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (cycle_count >= CALM_START && cycle_count < CALM_END)
            begin
                pop <= 1'b1;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    initial
    begin : stimulus
        int         i;
        int         pick;
        logic [1:0] rd;
        logic [1:0] rs;
        logic [1:0] rt;
        logic [3:0] imm;

        for (i = 0; i < 4; i++)
            reg_model[i] = '0;

        // Load the immediate extremes and show every register
        pending_instructions.push_back({OPC_LOAD, 2'd0, 4'h7});
        pending_instructions.push_back({OPC_LOAD, 2'd1, 4'h8});
        pending_instructions.push_back({OPC_LOAD, 2'd2, 4'h0});
        pending_instructions.push_back({OPC_LOAD, 2'd3, 4'hF});
        for (i = 0; i < 4; i++)
            pending_instructions.push_back(make_ins(OPC_MISC, 2'(i), 2'd0, EXT_DISPLAY));
        // Double r1 down to the most negative value, then wrap it to zero
        for (i = 0; i < 4; i++)
            pending_instructions.push_back(make_ins(OPC_ADD, 2'd1, 2'd1, 2'd1));
        pending_instructions.push_back(make_ins(OPC_MISC, 2'd1, 2'd0, EXT_DISPLAY));
        pending_instructions.push_back(make_ins(OPC_SUB, 2'd2, 2'd1, 2'd0));
        pending_instructions.push_back(make_ins(OPC_ADD, 2'd1, 2'd1, 2'd1));
        pending_instructions.push_back(make_ins(OPC_MISC, 2'd2, 2'd0, EXT_DISPLAY));
        // Compares, equal and not, then the undefined encoding
        pending_instructions.push_back(make_ins(OPC_MISC, 2'd1, 2'd2, EXT_CMP1));
        pending_instructions.push_back(make_ins(OPC_MISC, 2'd1, 2'd1, EXT_CMP1));
        pending_instructions.push_back(make_ins(OPC_MISC, 2'd0, 2'd0, EXT_CMP2));
        pending_instructions.push_back(make_ins(OPC_MISC, 2'd0, 2'd3, EXT_CMP2));
        pending_instructions.push_back(make_ins(OPC_MISC, 2'd2, 2'd1, EXT_INVALID));
        pending_instructions.push_back(8'hFF);
        pending_instructions.push_back(make_ins(OPC_MISC, 2'd2, 2'd0, EXT_DISPLAY));
        pending_instructions.push_back(8'h00);

        // Random part: raw bytes mixed with shaped loads, arithmetic, compares and displays
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 9);
            rd   = 2'($urandom_range(0, 3));
            rs   = 2'($urandom_range(0, 3));
            rt   = 2'($urandom_range(0, 3));
            imm  = 4'($urandom_range(0, 15));
            if (pick < 3)
                pending_instructions.push_back(8'($urandom_range(0, 255)));
            else if (pick < 5)
                pending_instructions.push_back({OPC_LOAD, rd, imm});
            else if (pick < 7)
                pending_instructions.push_back(make_ins(pick == 5 ? OPC_ADD : OPC_SUB,
                                                        rd, rs, rt));
            else if (pick < 9)
                // favour a compare of a register with itself now and then
                pending_instructions.push_back(make_ins(OPC_MISC, rd,
                                                        $urandom_range(0, 2) == 0 ? rd : rs,
                                                        $urandom_range(0, 1) ? EXT_CMP1
                                                                             : EXT_CMP2));
            else
                pending_instructions.push_back(make_ins(OPC_MISC, rd, rs, EXT_DISPLAY));
        end

        // Hold reset, then release it at a clock edge
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every beat to go in and every result to come out
        while (pending_instructions.size() != 0 || push || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
